>>> src/mppt_pkg.sv
`default_nettype none

package mppt_pkg;

  // fixed-point format of all voltages, currents and conductances
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  // differences and divider operands carry one extra bit
  localparam int DIV_W     = DATA_W + 1;
  localparam int HI_SHIFT  = DIV_W - FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);

  localparam logic [STEP_W-1:0] FIRST_STEP_RST =
    STEP_W'(((2 ** FRAC_BITS) * 2 + 50) / 100);

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes
  localparam logic REG_STEP_SIZE  = 1'b0;
  localparam logic REG_FIRST_STEP = 1'b1;

  typedef logic [3:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_DIFF,
    OP_DIV,
    OP_CMP,
    OP_DVZ,
    OP_FIRST,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_STARTED,
    C_DV_ZERO,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucw_t;

  typedef struct packed {
    logic in_fire;
    logic started;
    logic dv_zero;
    logic div_busy;
    logic out_busy;
  } flags_t;

  // program step labels
  localparam pc_t S_IDLE  = 4'd0;
  localparam pc_t S_DIFF  = 4'd1;
  localparam pc_t S_TEST  = 4'd2;
  localparam pc_t S_DIV   = 4'd3;
  localparam pc_t S_WAIT  = 4'd4;
  localparam pc_t S_CMP   = 4'd5;
  localparam pc_t S_DVZ   = 4'd6;
  localparam pc_t S_FIRST = 4'd7;
  localparam pc_t S_OUT   = 4'd8;
  localparam pc_t S_DONE  = 4'd9;

  // control store: a jump is taken when its condition holds, else pc + 1
  function automatic ucw_t mppt_ucode(input pc_t pc);
    ucw_t w;
    case (pc)
      S_IDLE:  w = '{op: OP_IDLE,  cond: C_NO_INPUT,    target: S_IDLE};
      S_DIFF:  w = '{op: OP_DIFF,  cond: C_NOT_STARTED, target: S_FIRST};
      S_TEST:  w = '{op: OP_NOP,   cond: C_DV_ZERO,     target: S_DVZ};
      S_DIV:   w = '{op: OP_DIV,   cond: C_NEVER,       target: S_IDLE};
      S_WAIT:  w = '{op: OP_NOP,   cond: C_DIV_BUSY,    target: S_WAIT};
      S_CMP:   w = '{op: OP_CMP,   cond: C_ALWAYS,      target: S_OUT};
      S_DVZ:   w = '{op: OP_DVZ,   cond: C_ALWAYS,      target: S_OUT};
      S_FIRST: w = '{op: OP_FIRST, cond: C_NEVER,       target: S_IDLE};
      S_OUT:   w = '{op: OP_OUT,   cond: C_OUT_BUSY,    target: S_OUT};
      S_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,      target: S_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,      target: S_IDLE};
    endcase
    return w;
  endfunction

  // saturate a 34-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W-1:0] r;
    if (!x[DATA_W+1] && (x[DATA_W:DATA_W-1] != 2'b00)) begin
      r = S32_MAX;
    end else if (x[DATA_W+1] && (x[DATA_W:DATA_W-1] != 2'b11)) begin
      r = S32_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // apply sign to a quotient magnitude and saturate
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                        input logic [DIV_W-1:0] mag);
    logic signed [DATA_W-1:0] r;
    if (neg) begin
      if (mag > {2'b01, {(DIV_W-2){1'b0}}}) begin
        r = S32_MIN;
      end else begin
        r = DATA_W'(-mag);
      end
    end else begin
      if (mag > {2'b00, {(DIV_W-2){1'b1}}}) begin
        r = S32_MAX;
      end else begin
        r = mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mppt_div.sv
`default_nettype none

// signed fixed-point divide (num << FRAC_BITS) / den, one quotient bit per cycle
module mppt_div
  import mppt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DIV_W-1:0]  num,
  input  wire logic signed [DIV_W-1:0]  den,
  output logic                          busy,
  output logic signed [DATA_W-1:0]      quo
);

  logic [DIV_W-1:0] nmag, dmag, hi;
  logic             ovf, neg;
  logic [DIV_W-1:0] rem_r, sh_r, dmag_r;
  logic             neg_r, busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [DATA_W-1:0] quo_r;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_nxt, sh_nxt;
  logic [DIV_W+FRAC_BITS-1:0] dvd;

  assign nmag = num[DIV_W-1] ? DIV_W'(-num) : num;
  assign dmag = den[DIV_W-1] ? DIV_W'(-den) : den;
  assign hi   = nmag >> HI_SHIFT;
  assign ovf  = hi >= dmag;   // also covers a zero divisor
  assign neg  = num[DIV_W-1] ^ den[DIV_W-1];
  assign dvd  = {nmag, {FRAC_BITS{1'b0}}};

  // restoring step
  assign trial   = {rem_r, sh_r[DIV_W-1]};
  assign ge      = trial >= {1'b0, dmag_r};
  assign rem_nxt = ge ? DIV_W'(trial - {1'b0, dmag_r}) : trial[DIV_W-1:0];
  assign sh_nxt  = {sh_r[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      neg_r  <= neg;
      dmag_r <= dmag;
      if (nmag == '0) begin
        quo_r  <= '0;
        busy_r <= 1'b0;
      end else if (ovf) begin
        quo_r  <= neg ? S32_MIN : S32_MAX;
        busy_r <= 1'b0;
      end else begin
        rem_r  <= hi;
        sh_r   <= dvd[DIV_W-1:0];
        cnt_r  <= CNT_W'(DIV_W);
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        quo_r  <= sat_mag(neg_r, sh_nxt);
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> src/mppt_seq.sv
`default_nettype none

// step counter over the control store with conditional jumps
module mppt_seq
  import mppt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output ucw_t        ctl
);

  pc_t  pc_r, pc_nxt;
  ucw_t ucw;
  logic take;

  assign ucw = mppt_ucode(pc_r);

  always_comb begin
    case (ucw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !flags.in_fire;
      C_NOT_STARTED: take = !flags.started;
      C_DV_ZERO:     take = flags.dv_zero;
      C_DIV_BUSY:    take = flags.div_busy;
      C_OUT_BUSY:    take = flags.out_busy;
      default:       take = 1'b1;
    endcase
    pc_nxt = take ? ucw.target : pc_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl = ucw;

endmodule

`default_nettype wire

>>> src/mppt_incremental_conductance_core.sv
`default_nettype none

// incremental-conductance mppt: one voltage reference per pv sample
// steps: form the differences, then divide and compare when the voltage moved
// (two 33-step serial dividers run side by side), else follow the current change;
// first sample after reset applies first_step; next sample waits until output loads
// reset: synchronous active-low rst_n clears history, started flag, output valid and
// registers (step_size 0, first_step 0.02 in fixed point)
module mppt_incremental_conductance_core
  import mppt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // [31:0] pv_voltage, [63:32] pv_current
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // [31:0] voltage_reference
  output logic [0:0]        out_tuser,  // [0] at_peak
  // configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // configuration registers
  logic [STEP_W-1:0] step_size_r, first_step_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= '0;
      first_step_r <= FIRST_STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_STEP_SIZE:  step_size_r  <= cfg_pwdata[STEP_W-1:0];
        REG_FIRST_STEP: first_step_r <= cfg_pwdata[STEP_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_STEP_SIZE:  cfg_prdata = {1'b0, step_size_r};
      REG_FIRST_STEP: cfg_prdata = {1'b0, first_step_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // sequencer
  ucw_t   ctl;
  flags_t flags;
  logic   in_fire, out_free;

  mppt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // datapath state
  logic signed [DATA_W-1:0] v_r, i_r, last_v_r, last_i_r, ref_r;
  logic signed [DIV_W-1:0]  dv_r, di_r;
  logic                     started_r, peak_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_ref_r;
  logic                     out_peak_r;

  assign in_tready = (ctl.op == OP_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // output register frees up when empty or drained this cycle
  assign out_free  = !out_valid_r || out_tready;

  // two dividers: conductance i/v and incremental conductance di/dv
  logic                     cond_busy, inc_busy;
  logic signed [DATA_W-1:0] cond_q, inc_q;
  logic                     div_start;

  assign div_start = (ctl.op == OP_DIV);

  mppt_div u_div_cond (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({i_r[DATA_W-1], i_r}),
    .den   ({v_r[DATA_W-1], v_r}),
    .busy  (cond_busy),
    .quo   (cond_q)
  );

  mppt_div u_div_inc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (di_r),
    .den   (dv_r),
    .busy  (inc_busy),
    .quo   (inc_q)
  );

  always_comb begin
    flags.in_fire  = in_fire;
    flags.started  = started_r;
    flags.dv_zero  = (dv_r == '0);
    flags.div_busy = cond_busy || inc_busy;
    flags.out_busy = !out_free;
  end

  // reference candidates, all saturated
  logic signed [DATA_W+1:0] v_ext;
  logic signed [DATA_W-1:0] ref_up, ref_dn, ref_first;
  logic signed [DIV_W-1:0]  neg_cond, inc_ext;

  assign v_ext     = {{2{v_r[DATA_W-1]}}, v_r};
  assign ref_up    = sat34(v_ext + $signed({3'b000, step_size_r}));
  assign ref_dn    = sat34(v_ext - $signed({3'b000, step_size_r}));
  assign ref_first = sat34(v_ext - $signed({3'b000, first_step_r}));
  // minus conductance at full width so the most negative value does not wrap
  assign neg_cond  = -$signed({cond_q[DATA_W-1], cond_q});
  assign inc_ext   = {inc_q[DATA_W-1], inc_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      last_v_r    <= '0;
      last_i_r    <= '0;
      ref_r       <= '0;
      peak_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        v_r <= in_tdata[31:0];
        i_r <= in_tdata[63:32];
      end

      case (ctl.op)
        OP_DIFF: begin
          // changes since the last sample, then remember this one
          dv_r     <= {v_r[DATA_W-1], v_r} - {last_v_r[DATA_W-1], last_v_r};
          di_r     <= {i_r[DATA_W-1], i_r} - {last_i_r[DATA_W-1], last_i_r};
          last_v_r <= v_r;
          last_i_r <= i_r;
        end
        OP_FIRST: begin
          ref_r     <= ref_first;
          peak_r    <= 1'b0;
          started_r <= 1'b1;
        end
        OP_DVZ: begin
          // voltage unchanged: follow the sign of the current change
          if (di_r == '0) begin
            peak_r <= 1'b1;
          end else if (di_r[DIV_W-1]) begin
            ref_r  <= ref_dn;
            peak_r <= 1'b0;
          end else begin
            ref_r  <= ref_up;
            peak_r <= 1'b0;
          end
        end
        OP_CMP: begin
          // di/dv against -i/v
          if (inc_ext == neg_cond) begin
            peak_r <= 1'b1;
          end else if (inc_ext > neg_cond) begin
            ref_r  <= ref_up;
            peak_r <= 1'b0;
          end else begin
            ref_r  <= ref_dn;
            peak_r <= 1'b0;
          end
        end
        default: ;
      endcase

      // output register: load when free, else drain on transaction
      if ((ctl.op == OP_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        out_ref_r   <= ref_r;
        out_peak_r  <= peak_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_ref_r;
  assign out_tuser[0] = out_peak_r;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mppt_pkg::*;

  // saturation bounds of a signed 32-bit word, held wide for the tracker math
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // register byte addresses
  localparam logic [2:0] STEP_ADDR  = {REG_STEP_SIZE, 2'b00};
  localparam logic [2:0] FIRST_ADDR = {REG_FIRST_STEP, 2'b00};

  // long receiver hold-off and one sender pause, placed mid-run
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 600;
  localparam int PAUSE_AT    = 700;
  // margin after the last result is taken, for the block to return to idle
  localparam int SETTLE      = 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;

  typedef enum {ROW_SAMPLE, ROW_STEP, ROW_FIRST} row_kind_t;

  // one row of the directed plan; config rows carry the register value in vin
  typedef struct {
    row_kind_t                 kind;
    logic signed [DATA_W-1:0]  vin;
    logic signed [DATA_W-1:0]  iin;
    bit                        fixed;
    logic signed [DATA_W-1:0]  vref;
    logic                      peak;
  } plan_row_t;

  typedef struct {
    logic signed [DATA_W-1:0]  voltage;
    logic signed [DATA_W-1:0]  current;
    bit                        fixed;
    logic signed [DATA_W-1:0]  vref;
    logic                      peak;
  } pv_sample_t;

  typedef struct {
    logic signed [DATA_W-1:0]  vref;
    logic                      peak;
  } reference_t;

  // directed plan: expectations typed in only where they are obvious
  plan_row_t plan [0:21] = '{
    // first sample after reset: reference sits the reset offset below the voltage
    '{ROW_SAMPLE, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'd64225,     1'b0},
    // nothing moved: hold at the peak
    '{ROW_SAMPLE, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'd64225,     1'b1},
    // current up with a zero step: reference lands on the voltage
    '{ROW_SAMPLE, 32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 1'b0},
    '{ROW_STEP,   32'h0000_0100, 32'h0,         1'b0, 32'h0,         1'b0},
    // offset only matters for the first sample, so no visible effect
    '{ROW_FIRST,  32'h7fff_ffff, 32'h0,         1'b0, 32'h0,         1'b0},
    // current down at the same voltage: one step below
    '{ROW_SAMPLE, 32'h0001_0000, 32'h0000_8000, 1'b1, 32'h0000_ff00, 1'b0},
    '{ROW_SAMPLE, 32'h0002_0000, 32'h0,         1'b0, 32'h0,         1'b0},
    // dI/dV equals -I/V exactly
    '{ROW_SAMPLE, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0,         1'b0},
    // zero voltage: conductance divides by zero
    '{ROW_SAMPLE, 32'h0,         32'h0000_0005, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
    // zero numerator on both quotients
    '{ROW_SAMPLE, 32'hffff_0000, 32'h0,         1'b0, 32'h0,         1'b0},
    // widest changes
    '{ROW_SAMPLE, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{ROW_STEP,   32'h7fff_ffff, 32'h0,         1'b0, 32'h0,         1'b0},
    // voltage plus step saturates high
    '{ROW_SAMPLE, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 32'h0,         1'b0, 32'h0,         1'b0},
    // voltage minus step saturates low
    '{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_SAMPLE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 32'h0,         1'b0},
    '{ROW_STEP,   32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_FIRST,  32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0000_0001, 32'h0000_0001, 1'b0, 32'h0,         1'b0}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;   // [31:0] pv_voltage, [63:32] pv_current
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [31:0] voltage_reference
  logic [0:0]  out_tuser;          // [0] at_peak
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mppt_incremental_conductance_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state mirrored in the testbench, plus shadow copies of the registers
  logic [STEP_W-1:0] step_shadow  = '0;
  logic [STEP_W-1:0] first_shadow = STEP_W'(((64'd1 << FRAC_BITS) * 2 + 50) / 100);
  longint            prev_voltage = 0;
  longint            prev_current = 0;
  longint            held_ref     = 0;
  bit                tracking     = 1'b0;

  pv_sample_t        pv_samples[$];     // samples waiting to be sent
  reference_t        expected_refs[$];  // references owed by the block
  bit                sample_busy = 1'b0; // a sample is on the bus, not yet taken
  int                samples_sent = 0;
  int                refs_seen    = 0;
  int                mismatches   = 0;
  bit                quiet_tx = 1'b0;
  bit                quiet_rx = 1'b0;

  // generator history, so random sequences can follow on from the last sample
  logic signed [DATA_W-1:0] gen_v = '0;
  logic signed [DATA_W-1:0] gen_i = '0;
  int                       walk_v = 30 * 65536;
  int                       walk_i = 5 * 65536;

  function automatic longint sat_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // fixed-point quotient, truncated toward zero, saturated; zero divisor goes to the rail unless num is zero
  function automatic longint fixed_quotient(input longint num, input longint den);
    if (den == 0) begin
      if (num > 0) return WORD_MAX;
      if (num < 0) return WORD_MIN;
      return 0;
    end
    return sat_word((num * (longint'(1) << FRAC_BITS)) / den);
  endfunction

  // next voltage reference for one accepted pv sample
  function automatic reference_t predict_reference(input logic signed [DATA_W-1:0] v_in,
                                                   input logic signed [DATA_W-1:0] i_in);
    reference_t r;
    longint v, i, dv, di, minus_g, inc_g, step;
    v    = v_in;
    i    = i_in;
    step = longint'(step_shadow);
    r.peak = 1'b0;
    if (!tracking) begin
      held_ref = sat_word(v - longint'(first_shadow));
      tracking = 1'b1;
    end else begin
      // 64-bit differences never wrap
      dv = v - prev_voltage;
      di = i - prev_current;
      if (dv == 0) begin
        if (di > 0) held_ref = sat_word(v + step);
        else if (di < 0) held_ref = sat_word(v - step);
        else r.peak = 1'b1;
      end else begin
        minus_g = -fixed_quotient(i, v);
        inc_g   = fixed_quotient(di, dv);
        if (inc_g == minus_g) r.peak = 1'b1;
        else if (inc_g > minus_g) held_ref = sat_word(v + step);
        else held_ref = sat_word(v - step);
      end
    end
    prev_voltage = v;
    prev_current = i;
    r.vref = held_ref[DATA_W-1:0];
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %0s: expected %h, got %h at %0t", what, want, got, $realtime);
  endfunction

  task automatic push_sample(input logic signed [DATA_W-1:0] v,
                             input logic signed [DATA_W-1:0] i,
                             input bit fixed, input logic signed [DATA_W-1:0] vref,
                             input logic peak);
    pv_sample_t s;
    s.voltage = v;
    s.current = i;
    s.fixed   = fixed;
    s.vref    = vref;
    s.peak    = peak;
    pv_samples.push_back(s);
    gen_v = v;
    gen_i = i;
  endtask

  function automatic logic signed [DATA_W-1:0] corner_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  // random samples, mostly shaped like a real tracker sees them
  task automatic queue_random_samples(input int count);
    int made, pick;
    logic signed [DATA_W-1:0] v, i;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // slow drift around an operating point
        walk_v = walk_v + int'($urandom_range(0, 32768)) - 16384;
        walk_i = walk_i + int'($urandom_range(0, 16384)) - 8192;
        push_sample(walk_v, walk_i, 1'b0, '0, 1'b0);
        made++;
      end else if (pick < 55) begin
        // voltage unchanged: current up, down or unchanged
        case ($urandom_range(0, 2))
          0:       i = gen_i + DATA_W'($urandom_range(1, 12288));
          1:       i = gen_i - DATA_W'($urandom_range(1, 12288));
          default: i = gen_i;
        endcase
        push_sample(gen_v, i, 1'b0, '0, 1'b0);
        made++;
      end else if (pick < 70) begin
        // (2v, 0) then (v, i): dI/dV lands on -I/V
        v = $signed($urandom) >>> 2;
        push_sample(v <<< 1, '0, 1'b0, '0, 1'b0);
        push_sample(v, $urandom, 1'b0, '0, 1'b0);
        made += 2;
      end else if (pick < 85) begin
        push_sample($urandom, $urandom, 1'b0, '0, 1'b0);
        made++;
      end else if (pick < 93) begin
        push_sample(corner_word(), corner_word(), 1'b0, '0, 1'b0);
        made++;
      end else begin
        // zero current with a moving voltage
        push_sample(gen_v + DATA_W'($urandom_range(1, 65536)), '0, 1'b0, '0, 1'b0);
        made++;
      end
    end
  endtask

  // block idle: nothing queued, nothing on the bus, nothing owed
  task automatic wait_idle();
    do @(posedge clk);
    while (pv_samples.size() != 0 || sample_busy || expected_refs.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write, then a read back of the same register
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] kept;
    kept = {1'b0, data[30:0]};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    // written at this edge
    if (addr == STEP_ADDR) step_shadow = kept[STEP_W-1:0];
    else first_shadow = kept[STEP_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (cfg_prdata !== kept) flag_mismatch("register read back", kept, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // sample source: predicts at each accepted transaction, may idle between items
  initial begin : sample_source
    pv_sample_t cur;
    reference_t owed;
    int         gap;
    bit         free;
    gap = 0;
    forever begin
      @(posedge clk);
      free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        owed = predict_reference(cur.voltage, cur.current);
        if (cur.fixed) begin
          owed.vref = cur.vref;
          owed.peak = cur.peak;
        end
        expected_refs.push_back(owed);
        samples_sent++;
        sample_busy = 1'b0;
        free = 1'b1;
      end
      if (free) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 1'b0;
        end else if (rst_n && pv_samples.size() != 0 &&
                     !(samples_sent == PAUSE_AT && expected_refs.size() != 0)) begin
          // the pause at PAUSE_AT lets every owed reference drain first
          cur = pv_samples.pop_front();
          sample_busy = 1'b1;
          in_tdata  <= {cur.current, cur.voltage};
          in_tvalid <= 1'b1;
          gap = quiet_tx ? 0 : $urandom_range(0, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // reference sink: checks each result transaction against the oldest owed one
  initial begin : reference_sink
    reference_t want;
    int         gap;
    int         hold;
    gap  = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        refs_seen++;
        if (expected_refs.size() == 0) begin
          flag_mismatch("unexpected reference", '0, out_tdata);
        end else begin
          want = expected_refs.pop_front();
          if (out_tdata !== want.vref)
            flag_mismatch("voltage_reference", want.vref, out_tdata);
          if (out_tuser[0] !== want.peak)
            flag_mismatch("at_peak", {31'b0, want.peak}, {31'b0, out_tuser[0]});
        end
        gap = quiet_rx ? 0 : $urandom_range(0, 10);
        // long stall so the block backs up and holds off its input
        if (refs_seen == HOLD_AT) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run control: reset, directed plan, random phases, drain, verdict
  initial begin : run_control
    logic [31:0] step_val;
    logic [31:0] first_val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      case (plan[k].kind)
        ROW_SAMPLE: begin
          push_sample(plan[k].vin, plan[k].iin, plan[k].fixed, plan[k].vref, plan[k].peak);
        end
        ROW_STEP: begin
          wait_idle();
          write_register(STEP_ADDR, plan[k].vin);
        end
        default: begin
          wait_idle();
          write_register(FIRST_ADDR, plan[k].vin);
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       step_val = 32'h0000_0001;
        1:       step_val = 32'h7fff_ffff;
        2:       step_val = 32'h0000_0000;
        3:       step_val = $urandom;
        default: step_val = $urandom_range(0, 32'h0000_ffff);
      endcase
      first_val = (p == 1) ? 32'hffff_ffff : $urandom;
      write_register(STEP_ADDR, step_val);
      write_register(FIRST_ADDR, first_val);
      // a few phases run back to back on one side or both
      quiet_tx = (p == 3) || (p == 6);
      quiet_rx = (p == 4) || (p == 6);
      queue_random_samples(PHASE_ITEMS);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
